// ----- hdl/tcbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console buffer engine package
// Item types, operation codes, register map and controller/datapath links.
// ----------------------------------------------------------------------------
package tcbe_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [4:0] row;
    } cmd_item_t;

    typedef struct packed {
        logic       status;
        logic [5:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } rsp_item_t;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [7:0] PRINTABLE_MIN = 8'd32;
    localparam logic [7:0] NEWLINE_CODE  = 8'd10;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_ATTR    = 2'd2;

    localparam logic [6:0] COLUMNS_RESET = 7'd64;
    localparam logic [5:0] ROWS_RESET    = 6'd32;
    localparam logic [7:0] ATTR_RESET    = 8'd7;

    typedef struct packed {
        logic accept;
        logic exec;
        logic copy;
        logic fill;
        logic init;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic need_scroll;
        logic copy_done;
        logic sweep_last;
        logic init_last;
        logic rsp_free;
    } dp_sts_t;

endpackage

// ----- hdl/tcbe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/tcbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console buffer engine controller
// Sequences init sweep, item execution, scroll copy, fills and result hand-off.
// ----------------------------------------------------------------------------
module tcbe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  tcbe_pkg::dp_sts_t sts,
    output tcbe_pkg::dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_COPY   = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init = 1'b1;
                if (sts.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (sts.op)
                    tcbe_pkg::OP_CLEAR: state_next = ST_FILL;
                    tcbe_pkg::OP_READ:  state_next = ST_RESULT;
                    tcbe_pkg::OP_PUT,
                    tcbe_pkg::OP_SET:
                    begin
                        priority if (sts.need_scroll)
                        begin
                            state_next = ST_COPY;
                        end
                        else if (sts.rsp_free)
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                endcase
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (sts.copy_done)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);

endmodule

// ----- hdl/tcbe_dp.sv -----
// ----------------------------------------------------------------------------
// Text console buffer engine datapath
// Cell store, cursor, sweep counter, address generation and result register.
// ----------------------------------------------------------------------------
module tcbe_dp #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcbe_pkg::dp_cmd_t   cmd,
    output tcbe_pkg::dp_sts_t   sts,
    input  tcbe_pkg::cmd_item_t cmd_item,
    input  logic [6:0]          columns_in_use,
    input  logic [5:0]          rows_in_use,
    input  logic [7:0]          current_attribute,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tcbe_pkg::rsp_item_t rsp_item
);

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = AW + 1;
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int MAX_G  = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int GW_RAW = $clog2(MAX_G + 1);
    localparam int GW     = (GW_RAW > 7) ? GW_RAW : 7;

    localparam logic [GW-1:0] MAXC_G   = GW'(MAX_COLUMNS);
    localparam logic [GW-1:0] MAXR_G   = GW'(MAX_ROWS);
    localparam logic [GW-1:0] ONE_G    = GW'(1);
    localparam logic [TW-1:0] INIT_END = TW'(DEPTH - 1);

    // item and state registers
    tcbe_pkg::op_t    op_reg;
    logic [7:0]       code_reg;
    logic [5:0]       col_reg;
    logic [4:0]       row_reg;
    logic [COL_W-1:0] cursor_x_reg, cursor_x_next;
    logic [ROW_W-1:0] cursor_y_reg, cursor_y_next;
    logic [TW-1:0]    total_reg;
    logic [TW-1:0]    cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    wr_addr_reg;
    logic             status_reg, status_next;
    logic             scrolled_reg, scrolled_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             rsp_valid_reg, rsp_valid_next;
    tcbe_pkg::rsp_item_t rsp_item_reg;

    // geometry
    logic [GW-1:0]   cols_cfg, rows_cfg, cols_eff, rows_eff;
    logic [2*GW-1:0] total_prod;

    assign cols_cfg = GW'(columns_in_use);
    assign rows_cfg = GW'(rows_in_use);
    assign cols_eff = (columns_in_use == '0) ? ONE_G :
                      (cols_cfg > MAXC_G) ? MAXC_G : cols_cfg;
    assign rows_eff = (rows_in_use == '0) ? ONE_G :
                      (rows_cfg > MAXR_G) ? MAXR_G : rows_cfg;
    assign total_prod = cols_eff * rows_eff;

    // put cursor arithmetic
    logic [GW-1:0] cx, cy, sx, sy, nx, nx_inc, ny_pre, ny;
    logic          printable, newline, put_scroll, in_range;

    assign cx = GW'(cursor_x_reg);
    assign cy = GW'(cursor_y_reg);
    assign sx = (cx >= cols_eff) ? cols_eff - ONE_G : cx;
    assign sy = (cy >= rows_eff) ? rows_eff - ONE_G : cy;
    assign printable = (code_reg >= tcbe_pkg::PRINTABLE_MIN);
    assign newline   = (code_reg == tcbe_pkg::NEWLINE_CODE);
    assign nx_inc    = sx + ONE_G;

    always_comb
    begin
        priority if (printable)
        begin
            if (nx_inc >= cols_eff)
            begin
                nx     = '0;
                ny_pre = sy + ONE_G;
            end
            else
            begin
                nx     = nx_inc;
                ny_pre = sy;
            end
        end
        else if (newline)
        begin
            nx     = '0;
            ny_pre = sy + ONE_G;
        end
        else
        begin
            nx     = sx;
            ny_pre = sy;
        end
    end

    assign put_scroll = (ny_pre >= rows_eff);
    assign ny         = put_scroll ? rows_eff - ONE_G : ny_pre;
    assign in_range   = (GW'(col_reg) < cols_eff) && (GW'(row_reg) < rows_eff);

    // cell address
    logic [GW-1:0]   mul_x, mul_y;
    logic [2*GW-1:0] addr_prod;
    logic [AW-1:0]   cell_addr;

    assign mul_x     = (op_reg == tcbe_pkg::OP_READ) ? GW'(col_reg) : sx;
    assign mul_y     = (op_reg == tcbe_pkg::OP_READ) ? GW'(row_reg) : sy;
    assign addr_prod = mul_y * cols_eff;
    assign cell_addr = addr_prod[AW-1:0] + AW'(mul_x);

    // sweep control
    logic [TW-1:0] cols_t, copy_lim, src_idx;
    logic          copy_more;

    assign cols_t    = TW'(cols_eff);
    assign copy_lim  = total_reg - cols_t;
    assign copy_more = (cnt_reg < copy_lim);
    assign src_idx   = cnt_reg + cols_t;

    // store
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [15:0]   ram_wr_data, ram_rd_data;

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg[AW-1:0];
        ram_wr_data = {current_attribute, 8'h00};
        ram_rd_en   = 1'b0;
        ram_rd_addr = src_idx[AW-1:0];
        priority if (cmd.init)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
        end
        else if (cmd.exec)
        begin
            ram_wr_en   = (op_reg == tcbe_pkg::OP_PUT) && printable;
            ram_wr_addr = cell_addr;
            ram_wr_data = {current_attribute, code_reg};
            ram_rd_en   = (op_reg == tcbe_pkg::OP_READ) && in_range;
            ram_rd_addr = cell_addr;
        end
        else if (cmd.copy)
        begin
            ram_wr_en   = pend_reg;
            ram_wr_addr = wr_addr_reg;
            ram_wr_data = ram_rd_data;
            ram_rd_en   = copy_more;
        end
        else if (cmd.fill)
        begin
            ram_wr_en = 1'b1;
        end
    end

    tcbe_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    logic status_c;

    assign status_c = ((op_reg == tcbe_pkg::OP_SET) || (op_reg == tcbe_pkg::OP_READ))
                      && !in_range;

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        status_next   = status_reg;
        scrolled_next = scrolled_reg;
        rd_ok_next    = rd_ok_reg;
        if (cmd.exec)
        begin
            cnt_next      = '0;
            status_next   = status_c;
            scrolled_next = (op_reg == tcbe_pkg::OP_PUT) && put_scroll;
            rd_ok_next    = (op_reg == tcbe_pkg::OP_READ) && in_range;
            unique case (op_reg)
                tcbe_pkg::OP_PUT:
                begin
                    cursor_x_next = COL_W'(nx);
                    cursor_y_next = ROW_W'(ny);
                end
                tcbe_pkg::OP_CLEAR:
                begin
                    cursor_x_next = '0;
                    cursor_y_next = '0;
                end
                tcbe_pkg::OP_SET:
                begin
                    if (in_range)
                    begin
                        cursor_x_next = COL_W'(col_reg);
                        cursor_y_next = ROW_W'(row_reg);
                    end
                end
                tcbe_pkg::OP_READ:
                begin
                    cursor_x_next = cursor_x_reg;
                end
            endcase
        end
        if (cmd.init || cmd.fill || (cmd.copy && copy_more))
        begin
            cnt_next = cnt_reg + TW'(1);
        end
        if (cmd.copy)
        begin
            pend_next = copy_more;
        end
    end

    // result
    logic                res_status, res_scrolled, res_rd_ok;
    tcbe_pkg::rsp_item_t res_item;

    assign res_status   = cmd.exec ? status_c : status_reg;
    assign res_scrolled = cmd.exec ? 1'b0 : scrolled_reg;
    assign res_rd_ok    = !cmd.exec && rd_ok_reg;

    always_comb
    begin
        res_item.status     = res_status;
        res_item.cursor_col = 6'(cursor_x_next);
        res_item.cursor_row = 5'(cursor_y_next);
        res_item.cell_char  = res_rd_ok ? ram_rd_data[7:0] : 8'h00;
        res_item.cell_attr  = res_rd_ok ? ram_rd_data[15:8] : 8'h00;
        res_item.scrolled   = res_scrolled;
    end

    assign rsp_valid_next = cmd.load ? 1'b1 : (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            status_reg    <= 1'b0;
            scrolled_reg  <= 1'b0;
            rd_ok_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            status_reg    <= status_next;
            scrolled_reg  <= scrolled_next;
            rd_ok_reg     <= rd_ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= cmd_item.operation;
            code_reg  <= cmd_item.char_code;
            col_reg   <= cmd_item.column;
            row_reg   <= cmd_item.row;
            total_reg <= total_prod[TW-1:0];
        end
        if (cmd.copy && copy_more)
        begin
            wr_addr_reg <= cnt_reg[AW-1:0];
        end
        if (cmd.load)
        begin
            rsp_item_reg <= res_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    assign sts.op          = op_reg;
    assign sts.need_scroll = (op_reg == tcbe_pkg::OP_PUT) && put_scroll;
    assign sts.copy_done   = !copy_more && !pend_reg;
    assign sts.sweep_last  = (cnt_reg == total_reg - TW'(1));
    assign sts.init_last   = (cnt_reg == INIT_END);
    assign sts.rsp_free    = !rsp_valid_reg || rsp_ready;

endmodule

// ----- hdl/text_console_buffer_engine.sv -----
// ----------------------------------------------------------------------------
// Text console buffer engine
// Character-cell text buffer with cursor, scroll, clear, set-cursor and read.
// ----------------------------------------------------------------------------
// Put and set-cursor load their result from the execute state when the output register
// is free, a read after the registered store read; clear sweeps all columns * rows in
// use cells, and a scrolling put copies every row up by one, then blanks the last row,
// the single write port of the cell store walked one cell per cycle. One item in flight;
// the next item is taken while a result waits in the output register.
// Reset: clearing pass over MAX_COLUMNS*MAX_ROWS cells (2048 by default), cmd_ready low.
module text_console_buffer_engine #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  tcbe_pkg::cmd_item_t cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tcbe_pkg::rsp_item_t rsp_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [6:0] columns_reg, columns_next;
    logic [5:0] rows_reg, rows_next;
    logic [7:0] attr_reg, attr_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        attr_next    = attr_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                tcbe_pkg::REG_COLUMNS: columns_next = pwdata[6:0];
                tcbe_pkg::REG_ROWS:    rows_next    = pwdata[5:0];
                tcbe_pkg::REG_ATTR:    attr_next    = pwdata[7:0];
                default:               attr_next    = attr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tcbe_pkg::REG_COLUMNS: prdata = 32'(columns_reg);
            tcbe_pkg::REG_ROWS:    prdata = 32'(rows_reg);
            tcbe_pkg::REG_ATTR:    prdata = 32'(attr_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= tcbe_pkg::COLUMNS_RESET;
            rows_reg    <= tcbe_pkg::ROWS_RESET;
            attr_reg    <= tcbe_pkg::ATTR_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            attr_reg    <= attr_next;
        end
    end

    tcbe_pkg::dp_cmd_t dp_cmd;
    tcbe_pkg::dp_sts_t dp_sts;

    tcbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    tcbe_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (dp_cmd),
        .sts               (dp_sts),
        .cmd_item          (cmd_item),
        .columns_in_use    (columns_reg),
        .rows_in_use       (rows_reg),
        .current_attribute (attr_reg),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .rsp_item          (rsp_item)
    );

endmodule

// ----- hdl/tcbe_check.sv -----
// ----------------------------------------------------------------------------
// Text console buffer engine port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcbe_check (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input tcbe_pkg::rsp_item_t rsp_item
);

    // stalled item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("rsp item changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item accepted while busy");

    // range error carries no cell and no scroll
    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status == tcbe_pkg::STATUS_RANGE) |->
            !rsp_item.scrolled && (rsp_item.cell_char == 8'h00)
            && (rsp_item.cell_attr == 8'h00))
        else $error("range error with cell data or scroll");

    // scroll leaves cursor at column zero
    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.scrolled |->
            (rsp_item.cursor_col == 6'd0) && (rsp_item.status == tcbe_pkg::STATUS_OK))
        else $error("scroll with cursor off column zero");

endmodule

bind text_console_buffer_engine tcbe_check u_tcbe_check (.*);
